// ----- rtl/core/fts_pkg.sv -----
// ============================================================================
// fts_pkg
// Shared widths, flag positions and helper types for the frame timestamp
// sanitizer.
// ============================================================================
package fts_pkg;

   // Internal time arithmetic width (two's complement, wraps at this width)
   localparam int TIME_BITS     = 64;
   localparam int IO_TIME_BITS  = 64;
   localparam int INTERVAL_BITS = 32;
   localparam int DELTA_BITS    = 63;
   localparam int SKIP_BITS     = 32;
   localparam int FLAG_BITS     = 6;

   // Divider step counter must hold TIME_BITS itself
   localparam int DIV_CNT_BITS  = $clog2(TIME_BITS + 1);

   // Stream payload widths, padded to whole bytes
   localparam int REQ_DATA_RAW  = 4 * IO_TIME_BITS + INTERVAL_BITS;
   localparam int REQ_DATA_BITS = ((REQ_DATA_RAW + 7) / 8) * 8;
   localparam int RSP_DATA_RAW  = 3 * IO_TIME_BITS + DELTA_BITS + SKIP_BITS + FLAG_BITS;
   localparam int RSP_DATA_BITS = ((RSP_DATA_RAW + 7) / 8) * 8;

   // Warning flag positions
   localparam int FLAG_FUTURE    = 0;
   localparam int FLAG_DEADLINE  = 1;
   localparam int FLAG_PRESENT   = 2;
   localparam int FLAG_LAG_SKIP  = 3;
   localparam int FLAG_FRAME_BWD = 4;
   localparam int FLAG_PRES_BWD  = 5;

   // Item kinds on req_tuser
   localparam logic KIND_UPDATE = 1'b0;
   localparam logic KIND_CLEAR  = 1'b1;

   typedef logic [TIME_BITS-1:0]     time_type;
   typedef logic [INTERVAL_BITS-1:0] interval_type;

   // Divider handshake status
   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

   // Signed less-than on internal time values
   function automatic logic time_lt(time_type a, time_type b);
      return $signed(a) < $signed(b);
   endfunction

   // Sign-extend an internal time to the port width
   function automatic logic [IO_TIME_BITS-1:0] time_out(time_type t);
      return IO_TIME_BITS'($signed(t));
   endfunction

endpackage

// ----- rtl/core/fts_divider.sv -----
// ============================================================================
// fts_divider
// Bit-serial restoring divider: one quotient bit per cycle, TIME_BITS quotient bits.
// ============================================================================
module fts_divider (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  fts_pkg::time_type                   dividend,
   input  fts_pkg::interval_type               divisor,
   output fts_pkg::div_status_type             status,
   output fts_pkg::time_type                   quotient,
   output fts_pkg::interval_type               remainder
);

   localparam int IB = fts_pkg::INTERVAL_BITS;

   // Dividend shifts out at the top while quotient bits shift in at the bottom
   fts_pkg::time_type                   quo_ff, quo_in;
   fts_pkg::interval_type               rem_ff, rem_in;
   fts_pkg::interval_type               dvs_ff, dvs_in;
   logic [fts_pkg::DIV_CNT_BITS-1:0]    cnt_ff, cnt_in;
   logic                                busy_ff, busy_in;
   logic                                done_ff, done_in;

   logic [IB:0] trial;
   logic        fits;

   // One trial subtract per cycle
   assign trial = {rem_ff, quo_ff[fts_pkg::TIME_BITS-1]};
   assign fits  = trial >= {1'b0, dvs_ff};

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
         cnt_in  = fts_pkg::DIV_CNT_BITS'(fts_pkg::TIME_BITS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in = {quo_ff[fts_pkg::TIME_BITS-2:0], fits};
         rem_in = fits ? IB'(trial - {1'b0, dvs_ff}) : trial[IB-1:0];
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == fts_pkg::DIV_CNT_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quotient    = quo_ff;
   assign remainder   = rem_ff;

endmodule

// ----- rtl/core/frame_timestamp_sanitizer.sv -----
// ============================================================================
// frame_timestamp_sanitizer
// Clamps and lag-corrects frame timestamps, tracks frame deltas and raises
// warning flags; lag mod interval comes from a bit-serial divider.
// ============================================================================
//  channel | ports         | payload
//  --------+---------------+-------------------------------------------------
//  input   | req_t*        | tuser: kind; tdata: times, interval, now
//  result  | rsp_t*        | tdata: clean times, delta, skips, warn flags
//
//  A frame update steps through the clamp, lag, history, delta and finish
//  states, plus divider and adjust states when lag correction runs; the
//  divider yields one quotient bit a cycle. A clear transfer yields no result.
//  Reset is synchronous and clears the tracker state and both handshakes.
//  A held result waits in the output register; the next item is accepted
//  meanwhile and only its own result stalls behind rsp_tready.
module frame_timestamp_sanitizer (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // tuser: kind
   input  logic                                 req_tuser,
   // tdata: reported_frame_time, reported_deadline, reported_presentation,
   //        interval, current_time
   input  logic [fts_pkg::REQ_DATA_BITS-1:0]    req_tdata,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // tdata: clean_frame_time, clean_deadline, clean_presentation,
   //        time_delta, frames_skipped, warn_flags, zero pad
   output logic [fts_pkg::RSP_DATA_BITS-1:0]    rsp_tdata
);

   localparam int TB = fts_pkg::TIME_BITS;
   localparam int IO = fts_pkg::IO_TIME_BITS;
   localparam int IB = fts_pkg::INTERVAL_BITS;
   localparam int DB = fts_pkg::DELTA_BITS;
   localparam int SB = fts_pkg::SKIP_BITS;
   localparam int FB = fts_pkg::FLAG_BITS;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CLAMP_DL,
      ST_CLAMP_PR,
      ST_LAG,
      ST_DIV_START,
      ST_DIV_WAIT,
      ST_ADJ_FT,
      ST_ADJ_DL,
      ST_ADJ_PR,
      ST_HIST_FT,
      ST_HIST_PR,
      ST_DELTA,
      ST_FINISH
   } state_type;

   state_type                 state_ff, state_in;
   fts_pkg::time_type         ft_ff, ft_in;
   fts_pkg::time_type         dl_ff, dl_in;
   fts_pkg::time_type         pr_ff, pr_in;
   fts_pkg::time_type         now_ff, now_in;
   fts_pkg::interval_type     iv_ff, iv_in;
   fts_pkg::time_type         lag_ff, lag_in;
   fts_pkg::time_type         adj_ff, adj_in;
   logic [SB-1:0]             skip_ff, skip_in;
   logic [FB-1:0]             flags_ff, flags_in;
   fts_pkg::time_type         last_ft_ff, last_ft_in;
   fts_pkg::time_type         last_pr_ff, last_pr_in;
   logic                      seen_ff, seen_in;
   logic [DB-1:0]             last_delta_ff, last_delta_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [fts_pkg::RSP_DATA_BITS-1:0] rsp_data_ff, rsp_data_in;
   logic                      div_start;

   fts_pkg::div_status_type   div_status;
   fts_pkg::time_type         div_quo;
   fts_pkg::interval_type     div_rem;
   fts_pkg::time_type         diff;

   // Input field unpacking, truncated to the internal width
   fts_pkg::time_type         in_ft, in_dl, in_pr, in_now;
   fts_pkg::interval_type     in_iv;

   assign in_ft  = req_tdata[TB-1:0];
   assign in_dl  = req_tdata[IO+TB-1:IO];
   assign in_pr  = req_tdata[2*IO+TB-1:2*IO];
   assign in_iv  = req_tdata[3*IO+IB-1:3*IO];
   assign in_now = req_tdata[3*IO+IB+TB-1:3*IO+IB];

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Shared subtractor for lag and delta steps
   assign diff = (state_ff == ST_DELTA) ? ft_ff - last_ft_ff : now_ff - ft_ff;

   fts_divider u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (lag_ff),
      .divisor   (iv_ff),
      .status    (div_status),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   // Sequencer: one clamp, adjustment or history step per state
   always_comb begin
      state_in      = state_ff;
      ft_in         = ft_ff;
      dl_in         = dl_ff;
      pr_in         = pr_ff;
      now_in        = now_ff;
      iv_in         = iv_ff;
      lag_in        = lag_ff;
      adj_in        = adj_ff;
      skip_in       = skip_ff;
      flags_in      = flags_ff;
      last_ft_in    = last_ft_ff;
      last_pr_in    = last_pr_ff;
      seen_in       = seen_ff;
      last_delta_in = last_delta_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      div_start     = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               if (req_tuser == fts_pkg::KIND_CLEAR) begin
                  last_ft_in    = '0;
                  last_pr_in    = '0;
                  seen_in       = 1'b0;
                  last_delta_in = '0;
               end else begin
                  // Frame time no later than now
                  flags_in = '0;
                  skip_in  = '0;
                  now_in   = in_now;
                  iv_in    = in_iv;
                  dl_in    = in_dl;
                  pr_in    = in_pr;
                  if (fts_pkg::time_lt(in_now, in_ft)) begin
                     ft_in = in_now;
                     flags_in[fts_pkg::FLAG_FUTURE] = 1'b1;
                  end else begin
                     ft_in = in_ft;
                  end
                  state_in = ST_CLAMP_DL;
               end
            end
         end
         ST_CLAMP_DL: begin
            if (fts_pkg::time_lt(dl_ff, ft_ff)) begin
               dl_in = ft_ff;
               flags_in[fts_pkg::FLAG_DEADLINE] = 1'b1;
            end
            state_in = ST_CLAMP_PR;
         end
         ST_CLAMP_PR: begin
            if (fts_pkg::time_lt(pr_ff, dl_ff)) begin
               pr_in = dl_ff;
               flags_in[fts_pkg::FLAG_PRESENT] = 1'b1;
            end
            lag_in   = diff;
            state_in = ST_LAG;
         end
         ST_LAG: begin
            if (iv_ff != '0 && lag_ff >= TB'(iv_ff)) begin
               state_in = ST_DIV_START;
            end else begin
               state_in = ST_HIST_FT;
            end
         end
         ST_DIV_START: begin
            div_start = 1'b1;
            state_in  = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (div_status.done) begin
               skip_in  = (div_quo > TB'({SB{1'b1}})) ? {SB{1'b1}} : SB'(div_quo);
               adj_in   = lag_ff - TB'(div_rem);
               flags_in[fts_pkg::FLAG_LAG_SKIP] = 1'b1;
               state_in = ST_ADJ_FT;
            end
         end
         ST_ADJ_FT: begin
            ft_in    = now_ff - TB'(div_rem);
            state_in = ST_ADJ_DL;
         end
         ST_ADJ_DL: begin
            dl_in    = dl_ff + adj_ff;
            state_in = ST_ADJ_PR;
         end
         ST_ADJ_PR: begin
            pr_in    = pr_ff + adj_ff;
            state_in = ST_HIST_FT;
         end
         ST_HIST_FT: begin
            // Monotonic frame time after the first frame
            if (seen_ff && fts_pkg::time_lt(ft_ff, last_ft_ff)) begin
               ft_in = last_ft_ff;
               flags_in[fts_pkg::FLAG_FRAME_BWD] = 1'b1;
            end
            state_in = ST_HIST_PR;
         end
         ST_HIST_PR: begin
            if (seen_ff && fts_pkg::time_lt(pr_ff, last_pr_ff)) begin
               pr_in = last_pr_ff;
               flags_in[fts_pkg::FLAG_PRES_BWD] = 1'b1;
            end
            state_in = ST_DELTA;
         end
         ST_DELTA: begin
            // Delta saturates when it does not fit the output field
            if (seen_ff) begin
               if (TB > DB && diff[TB-1]) begin
                  last_delta_in = {DB{1'b1}};
               end else begin
                  last_delta_in = DB'(diff);
               end
            end
            seen_in    = 1'b1;
            last_ft_in = ft_ff;
            last_pr_in = pr_ff;
            state_in   = ST_FINISH;
         end
         ST_FINISH: begin
            // Load the output register once it is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = fts_pkg::RSP_DATA_BITS'({flags_ff, skip_ff, last_delta_ff,
                                                       fts_pkg::time_out(pr_ff),
                                                       fts_pkg::time_out(dl_ff),
                                                       fts_pkg::time_out(ft_ff)});
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         last_ft_ff    <= '0;
         last_pr_ff    <= '0;
         seen_ff       <= 1'b0;
         last_delta_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         last_ft_ff    <= last_ft_in;
         last_pr_ff    <= last_pr_in;
         seen_ff       <= seen_in;
         last_delta_ff <= last_delta_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      ft_ff       <= ft_in;
      dl_ff       <= dl_in;
      pr_ff       <= pr_in;
      now_ff      <= now_in;
      iv_ff       <= iv_in;
      lag_ff      <= lag_in;
      adj_ff      <= adj_in;
      skip_ff     <= skip_in;
      flags_ff    <= flags_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

// ----- test/frame_timestamp_sanitizer_tb.sv -----
`timescale 1ns / 100ps
// ============================================================================
// frame_timestamp_sanitizer_tb
// Drives frame update and clear transfers into the sanitizer, predicts each
// cleaned frame from a local copy of the tracker state and checks every
// result transfer field by field. A directed table covers the corner cases
// and is followed by a long random phase. Both sides idle at random, and the
// result side also holds off once for a long stretch to back up the block.
// ============================================================================
module frame_timestamp_sanitizer_tb;

   localparam logic [63:0] T_MIN     = 64'h8000_0000_0000_0000;
   localparam logic [63:0] T_MAX     = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [62:0] DELTA_CAP = '1;
   localparam logic [63:0] TIME_MASK = {64{1'b1}} >> (64 - fts_pkg::TIME_BITS);
   localparam logic [63:0] TIME_SIGN = 64'd1 << (fts_pkg::TIME_BITS - 1);

   // Warning flag values
   localparam logic [5:0] F_FUTURE    = 6'd1 << fts_pkg::FLAG_FUTURE;
   localparam logic [5:0] F_DEADLINE  = 6'd1 << fts_pkg::FLAG_DEADLINE;
   localparam logic [5:0] F_PRESENT   = 6'd1 << fts_pkg::FLAG_PRESENT;
   localparam logic [5:0] F_LAG       = 6'd1 << fts_pkg::FLAG_LAG_SKIP;
   localparam logic [5:0] F_FRAME_BWD = 6'd1 << fts_pkg::FLAG_FRAME_BWD;
   localparam logic [5:0] F_PRES_BWD  = 6'd1 << fts_pkg::FLAG_PRES_BWD;

   typedef struct {
      logic        kind;
      logic [63:0] frame;
      logic [63:0] deadline;
      logic [63:0] presentation;
      logic [31:0] interval;
      logic [63:0] cur_time;
   } frame_req_type;

   typedef struct {
      logic [63:0] frame;
      logic [63:0] deadline;
      logic [63:0] presentation;
      logic [62:0] delta;
      logic [31:0] skipped;
      logic [5:0]  flags;
   } clean_frame_type;

   typedef struct {
      frame_req_type   req;
      bit              typed;
      clean_frame_type rsp;
   } directed_row_type;

   logic                              clock      = 1'b0;
   logic                              reset      = 1'b1;
   logic                              req_tvalid = 1'b0;
   logic                              req_tready;
   logic                              req_tuser  = fts_pkg::KIND_UPDATE;
   logic [fts_pkg::REQ_DATA_BITS-1:0] req_tdata  = '0;
   logic                              rsp_tvalid;
   logic                              rsp_tready = 1'b0;
   logic [fts_pkg::RSP_DATA_BITS-1:0] rsp_tdata;

   // Tracker state as the predictor sees it
   logic [63:0]  track_frame;
   logic [63:0]  track_presentation;
   logic         track_seen;
   logic [63:0]  track_delta;

   clean_frame_type pending_clean_q[$];
   int              mismatches = 0;
   int              sent_count = 0;
   bit              no_idle    = 1'b0;
   logic [63:0]     corner [5] = '{T_MIN, T_MAX, 64'd0, '1, 64'd1};

   frame_timestamp_sanitizer DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #6 clock = ~clock;

   // Truncate to the time width and sign-extend
   function automatic logic [63:0] to_time(logic [63:0] v);
      return ((v & TIME_MASK) ^ TIME_SIGN) - TIME_SIGN;
   endfunction

   function automatic bit time_before(logic [63:0] a, logic [63:0] b);
      return $signed(a) < $signed(b);
   endfunction

   // Sanitize one item against the tracker state; returns 1 when a result is due
   function automatic bit sanitize_frame(input frame_req_type r,
                                         output clean_frame_type o);
      logic [63:0] ft, dl, pr, now, iv, lag, off, quo, d;
      o = '{default: '0};
      if (r.kind == fts_pkg::KIND_CLEAR) begin
         track_frame        = '0;
         track_presentation = '0;
         track_seen         = 1'b0;
         track_delta        = '0;
         return 1'b0;
      end
      ft  = to_time(r.frame);
      dl  = to_time(r.deadline);
      pr  = to_time(r.presentation);
      now = to_time(r.cur_time);
      iv  = {32'd0, r.interval};

      // clamp order: frame to now, deadline to frame, presentation to deadline
      if (time_before(now, ft)) begin
         ft = now;
         o.flags |= F_FUTURE;
      end
      if (time_before(dl, ft)) begin
         dl = ft;
         o.flags |= F_DEADLINE;
      end
      if (time_before(pr, dl)) begin
         pr = dl;
         o.flags |= F_PRESENT;
      end

      // lag correction snaps to the last whole interval
      lag = (now - ft) & TIME_MASK;
      if (iv != 0 && lag >= iv) begin
         off       = lag % iv;
         quo       = lag / iv;
         o.skipped = (quo > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : quo[31:0];
         ft        = to_time(now - off);
         dl        = to_time(dl + (lag - off));
         pr        = to_time(pr + (lag - off));
         o.flags  |= F_LAG;
      end

      // monotonic against the previous frame
      if (track_seen) begin
         if (time_before(ft, track_frame)) begin
            ft = track_frame;
            o.flags |= F_FRAME_BWD;
         end
         if (time_before(pr, track_presentation)) begin
            pr = track_presentation;
            o.flags |= F_PRES_BWD;
         end
         d = (ft - track_frame) & TIME_MASK;
         track_delta = (d > {1'b0, DELTA_CAP}) ? {1'b0, DELTA_CAP} : d;
      end
      track_seen         = 1'b1;
      track_frame        = ft;
      track_presentation = pr;

      o.frame        = ft;
      o.deadline     = dl;
      o.presentation = pr;
      o.delta        = track_delta[62:0];
      return 1'b1;
   endfunction

   // One input transfer; the prediction is made at the accepting edge
   task automatic send_request(input frame_req_type r, input bit typed,
                               input clean_frame_type typed_rsp);
      clean_frame_type predicted;
      while (!no_idle && $urandom_range(0, 99) < 21) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= r.kind;
      req_tdata  <= {r.cur_time, r.interval, r.presentation, r.deadline, r.frame};
      do @(posedge clock); while (!req_tready);
      if (sanitize_frame(r, predicted))
         pending_clean_q.push_back(typed ? typed_rsp : predicted);
      sent_count++;
   endtask

   task automatic check_field(string what, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         mismatches++;
         if (mismatches <= 10)
            $display("mismatch on %s: expected %h, got %h", what, want, got);
      end
   endtask

   // Result checker
   always @(posedge clock) begin
      clean_frame_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_clean_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("result transfer with nothing pending: %h", rsp_tdata);
         end else begin
            want = pending_clean_q.pop_front();
            check_field("frame time", want.frame, rsp_tdata[63:0]);
            check_field("deadline", want.deadline, rsp_tdata[127:64]);
            check_field("presentation", want.presentation, rsp_tdata[191:128]);
            check_field("delta", {1'b0, want.delta}, {1'b0, rsp_tdata[254:192]});
            check_field("frames skipped", 64'(want.skipped), 64'(rsp_tdata[286:255]));
            check_field("warn flags", 64'(want.flags), 64'(rsp_tdata[292:287]));
         end
      end
   end

   // Result side: random stalls, one long hold-off once traffic is flowing
   initial begin : receiver
      int  hold_left;
      bit  held;
      hold_left = 0;
      held      = 1'b0;
      forever begin
         @(posedge clock);
         if (!held && sent_count >= 300) begin
            held      = 1'b1;
            hold_left = 400;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= no_idle || ($urandom_range(0, 99) >= 21);
         end
      end
   end

   // Run limit
   initial begin
      #(64'd600_000 * 12);
      $display("frame_timestamp_sanitizer test failed");
      $finish;
   end

   // Stimulus
   initial begin : stimulus
      directed_row_type rows[$];
      frame_req_type    r;
      clean_frame_type  none;
      logic [63:0]      stream_now;
      logic [63:0]      lag;
      int               pick;

      none       = '{default: '0};
      stream_now = {$urandom, $urandom};

      // after reset: first frame keeps the zero delta
      rows.push_back('{'{fts_pkg::KIND_UPDATE, 64'd0, 64'd0, 64'd0, 32'd0, 64'd0}, 1'b1,
                       '{64'd0, 64'd0, 64'd0, 63'd0, 32'd0, 6'd0}});
      rows.push_back('{'{fts_pkg::KIND_CLEAR, 64'hDEAD_BEEF_0000_0001, '1, 64'd5, '1,
                         T_MIN}, 1'b0, none});
      // frame in the future, presentation before deadline
      rows.push_back('{'{fts_pkg::KIND_UPDATE, 64'd100, 64'd50, 64'd10, 32'd0, 64'd40},
                       1'b1,
                       '{64'd40, 64'd50, 64'd50, 63'd0, 32'd0, F_FUTURE | F_PRESENT}});
      rows.push_back('{'{fts_pkg::KIND_CLEAR, '0, '0, '0, '0, '0}, 1'b0, none});
      // lag of three and a half intervals
      rows.push_back('{'{fts_pkg::KIND_UPDATE, 64'd0, 64'd0, 64'd0, 32'd10, 64'd35}, 1'b1,
                       '{64'd30, 64'd30, 64'd30, 63'd0, 32'd3, F_LAG}});
      // frame and presentation going backwards
      rows.push_back('{'{fts_pkg::KIND_UPDATE, 64'd20, 64'd25, 64'd25, 32'd0, 64'd100},
                       1'b1,
                       '{64'd30, 64'd25, 64'd30, 63'd0, 32'd0, F_FRAME_BWD | F_PRES_BWD}});
      rows.push_back('{'{fts_pkg::KIND_UPDATE, 64'd130, 64'd200, 64'd300, 32'd0, 64'd130},
                       1'b1,
                       '{64'd130, 64'd200, 64'd300, 63'd100, 32'd0, 6'd0}});
      rows.push_back('{'{fts_pkg::KIND_CLEAR, T_MAX, T_MIN, T_MAX, 32'd7, 64'd9}, 1'b0,
                       none});
      // full range lag with unit interval: skip count saturates, shifted times wrap
      rows.push_back('{'{fts_pkg::KIND_UPDATE, T_MIN, T_MIN, T_MIN, 32'd1, T_MAX}, 1'b1,
                       '{T_MAX, T_MAX, T_MAX, 63'd0, 32'hFFFF_FFFF, F_LAG}});
      rows.push_back('{'{fts_pkg::KIND_UPDATE, T_MIN, T_MIN, T_MIN, 32'd0, T_MIN}, 1'b1,
                       '{T_MAX, T_MIN, T_MAX, 63'd0, 32'd0, F_FRAME_BWD | F_PRES_BWD}});
      rows.push_back('{'{fts_pkg::KIND_CLEAR, '0, '0, '0, '0, '0}, 1'b0, none});
      rows.push_back('{'{fts_pkg::KIND_UPDATE, T_MIN, T_MIN, T_MIN, 32'd0, T_MIN}, 1'b1,
                       '{T_MIN, T_MIN, T_MIN, 63'd0, 32'd0, 6'd0}});
      // delta beyond the 63-bit range saturates
      rows.push_back('{'{fts_pkg::KIND_UPDATE, T_MAX, T_MAX, T_MAX, 32'hFFFF_FFFF,
                         T_MAX}, 1'b1,
                       '{T_MAX, T_MAX, T_MAX, DELTA_CAP, 32'd0, 6'd0}});
      // deadline before frame, presentation before deadline, plus both backwards clamps
      rows.push_back('{'{fts_pkg::KIND_UPDATE, 64'd50, 64'd10, 64'd5, 32'd0, 64'd60},
                       1'b1,
                       '{T_MAX, 64'd50, T_MAX, 63'd0, 32'd0,
                         F_DEADLINE | F_PRESENT | F_FRAME_BWD | F_PRES_BWD}});
      rows.push_back('{'{fts_pkg::KIND_CLEAR, '1, '1, '1, '1, '1}, 1'b0, none});
      // wrap of shifted deadline and presentation
      rows.push_back('{'{fts_pkg::KIND_UPDATE, T_MIN, T_MAX, T_MAX, 32'd3, 64'd0}, 1'b0,
                       none});
      // lag exactly one interval, then just below one
      rows.push_back('{'{fts_pkg::KIND_UPDATE, 64'd0, 64'd0, 64'd0, 32'd1000, 64'd1000},
                       1'b0, none});
      rows.push_back('{'{fts_pkg::KIND_UPDATE, 64'd2000, 64'd2100, 64'd2200, 32'd1001,
                         64'd3000}, 1'b0, none});
      rows.push_back('{'{fts_pkg::KIND_UPDATE, 64'd0, 64'd0, 64'd0, 32'hFFFF_FFFF,
                         64'h0000_0100_0000_0000}, 1'b0, none});
      rows.push_back('{'{fts_pkg::KIND_UPDATE, {$urandom, $urandom}, {$urandom, $urandom},
                         {$urandom, $urandom}, 32'h8000_0001, {$urandom, $urandom}},
                       1'b0, none});

      track_frame        = '0;
      track_presentation = '0;
      track_seen         = 1'b0;
      track_delta        = '0;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (rows[i])
         send_request(rows[i].req, rows[i].typed, rows[i].rsp);

      // random phase: mostly plausible frame streams, some noise and corners
      for (int n = 0; n < 930; n++) begin
         no_idle        = (n >= 450 && n < 600);
         pick           = $urandom_range(0, 99);
         r.kind         = fts_pkg::KIND_UPDATE;
         r.frame        = {$urandom, $urandom};
         r.deadline     = {$urandom, $urandom};
         r.presentation = {$urandom, $urandom};
         r.interval     = $urandom;
         r.cur_time     = {$urandom, $urandom};
         if (pick < 5) begin
            r.kind = fts_pkg::KIND_CLEAR;
         end else if (pick < 25) begin
            if ($urandom_range(0, 1) == 0)
               r.interval = $urandom_range(0, 64);
         end else if (pick < 32) begin
            r.frame        = corner[$urandom_range(0, 4)];
            r.deadline     = corner[$urandom_range(0, 4)];
            r.presentation = corner[$urandom_range(0, 4)];
            r.interval     = corner[$urandom_range(0, 4)][31:0];
            r.cur_time     = corner[$urandom_range(0, 4)];
         end else begin
            case ($urandom_range(0, 4))
               0:       r.interval = 32'd0;
               1:       r.interval = 32'd16667;
               2:       r.interval = 32'd33333;
               3:       r.interval = $urandom_range(1, 64);
               default: r.interval = $urandom;
            endcase
            stream_now += 64'($urandom_range(0, 100000));
            if ($urandom_range(0, 19) == 0)
               stream_now -= 64'($urandom_range(0, 200000));
            case ($urandom_range(0, 9))
               0:       lag = {$urandom, $urandom} >> $urandom_range(0, 63);
               1:       lag = -64'($urandom_range(1, 500));
               default: lag = 64'(r.interval) * $urandom_range(0, 3)
                              + 64'($urandom_range(0, r.interval));
            endcase
            r.cur_time = stream_now;
            r.frame    = stream_now - lag;
            if ($urandom_range(0, 9) == 0)
               r.deadline = r.frame - 64'($urandom_range(1, 1000));
            else
               r.deadline = r.frame + 64'($urandom_range(0, r.interval));
            if ($urandom_range(0, 9) == 0)
               r.presentation = r.deadline - 64'($urandom_range(1, 1000));
            else
               r.presentation = r.deadline + 64'($urandom_range(0, 50000));
         end
         send_request(r, 1'b0, none);
      end
      no_idle = 1'b0;
      req_tvalid <= 1'b0;

      while (pending_clean_q.size() > 0)
         @(posedge clock);
      repeat (100) @(posedge clock);
      if (mismatches == 0)
         $display("frame_timestamp_sanitizer test passed");
      else
         $display("frame_timestamp_sanitizer test failed");
      $finish;
   end

endmodule
